// ----- sv/szdd_pkg.sv -----
// szdd_pkg: shared types and constants for the SZDD LZSS decompressor.
// No dependencies.

package szdd_pkg;

    localparam int WINDOW_SIZE  = 4096;
    localparam int WIN_AW       = 12;
    localparam int MIN_MATCH    = 3;
    localparam int HEADER_BYTES = 14;

    localparam logic [31:0] SIG_SZDD    = 32'h4444_5A53;
    localparam logic [31:0] SIG_KWAJ    = 32'h4A41_574B;
    localparam logic [31:0] MAGIC_CONST = 32'h3327_F088;
    localparam logic [7:0]  TYPE_A      = 8'h41;
    localparam logic [7:0]  FILL_SPACE  = 8'h20;
    localparam logic [7:0]  FILL_ZERO   = 8'h00;

    localparam logic [31:0] MAX_LEN_RESET = 32'hFFFF_FFFF;
    localparam logic [11:0] WSTART_RESET  = 12'd4080;

    // config register indexes
    localparam logic CFG_MAX_LEN = 1'b0;
    localparam logic CFG_WSTART  = 1'b1;

    // result status codes
    localparam logic [3:0] ST_DATA      = 4'd0;
    localparam logic [3:0] ST_DONE      = 4'd1;
    localparam logic [3:0] ST_TOO_SMALL = 4'd2;
    localparam logic [3:0] ST_KWAJ      = 4'd3;
    localparam logic [3:0] ST_BAD_SIG   = 4'd4;
    localparam logic [3:0] ST_BAD_CONST = 4'd5;
    localparam logic [3:0] ST_BAD_TYPE  = 4'd6;
    localparam logic [3:0] ST_TOO_BIG   = 4'd7;
    localparam logic [3:0] ST_TRUNC_REF = 4'd8;
    localparam logic [3:0] ST_TRUNC_OUT = 4'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_COPY_RD,
        S_COPY_WR,
        S_END
    } t_state;

    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [WIN_AW-1:0] raddr;
    } t_win_req;

endpackage

// ----- sv/szdd_ram.sv -----
// szdd_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.

module szdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/szdd_win.sv -----
// szdd_win: 4 KB history window. Entries not yet written since the last refill
// read as spaces below the start position and zeros from it up.
// Depends on szdd_pkg, szdd_ram.

module szdd_win (
    input  logic                        i_clk,
    input  szdd_pkg::t_win_req          i_req,
    input  logic [szdd_pkg::WIN_AW-1:0] i_start,
    input  logic [szdd_pkg::WIN_AW:0]   i_fill,
    output logic [7:0]                  o_rdata
);

    logic [szdd_pkg::WIN_AW-1:0] offs;
    logic                        written;
    logic [7:0]                  dflt;
    logic                        r_written;
    logic [7:0]                  r_dflt;
    logic [7:0]                  ram_q;

    // writes run contiguously from the start position, so a fill count says it all
    assign offs    = i_req.raddr - i_start;
    assign written = {1'b0, offs} < i_fill;
    assign dflt    = (i_req.raddr < i_start) ? szdd_pkg::FILL_SPACE : szdd_pkg::FILL_ZERO;

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_written <= written;
            r_dflt    <= dflt;
        end
    end

    szdd_ram #(
        .WIDTH(8),
        .DEPTH(szdd_pkg::WINDOW_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.we),
        .i_waddr (i_req.waddr),
        .i_wdata (i_req.wdata),
        .i_re    (i_req.re),
        .i_raddr (i_req.raddr),
        .o_rdata (ram_q)
    );

    assign o_rdata = r_written ? ram_q : r_dflt;

endmodule

// ----- sv/szdd_lzss_decompressor.sv -----
// szdd_lzss_decompressor: SZDD header parser and LZSS decoder, top level.
// Depends on szdd_pkg, szdd_win.
//
// Input stream: one file byte per word on tdata, tlast marks the last byte of
// the file. Output stream: tdata is the decoded byte, tuser the status
// (0 data, 1 done, 2 too small, 3 KWAJ, 4 bad signature, 5 bad constant,
// 6 bad type, 7 too big, 8 truncated reference, 9 truncated output), tlast
// flags the final result caused by an input byte.
// Config port: index 0 max original size, index 1 window start (refills window).
// Write config only while idle.
// Timing: a byte is taken in the idle state and decoded in the next cycle.
// For the second byte of a back-reference, each copied byte is a
// registered window read followed by the write-back of that byte into the
// window. A final byte, unless the header has failed, then passes through an
// end state for the status result.
// A result sits in the output register; the sequencer waits there while the
// receiver stalls and accepts no new byte. Reset (synchronous, active low)
// clears the decoder; the window needs no clearing pass since a fill count
// marks which entries hold data.

module szdd_lzss_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic [3:0]  o_m_axis_tuser,   // [3:0] status
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    localparam int AW = szdd_pkg::WIN_AW;

    szdd_pkg::t_state   r_state, n_state;
    szdd_pkg::t_win_req win_req;

    logic [31:0]   r_max_len;
    logic [AW-1:0] r_wstart;
    logic [AW-1:0] r_wpos;
    logic [AW:0]   r_fill;
    logic [3:0]    r_hdr_cnt;
    logic [63:0]   r_hdr;
    logic [7:0]    r_type;
    logic [31:0]   r_size;
    logic [31:0]   r_prod;
    logic [7:0]    r_flag;
    logic [3:0]    r_fidx;
    logic [8:0]    r_pend;
    logic          r_err;
    logic [7:0]    r_in_byte;
    logic          r_in_end;
    logic [AW-1:0] r_pos;
    logic [4:0]    r_left;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic [3:0]    r_ostat;
    logic          r_olast;

    logic          out_can;
    logic          hdr_phase;
    logic          hdr_last;
    logic [31:0]   size_new;
    logic [3:0]    hdr_code;
    logic          hdr_err;
    logic          dec_act;
    logic          is_ctrl;
    logic          is_lit;
    logic          is_hold;
    logic          is_copy;
    logic          copy_done;
    logic [3:0]    end_code;
    logic [7:0]    win_q;

    logic          out_load;
    logic [7:0]    out_byte;
    logic [3:0]    out_stat;
    logic          out_last;
    logic          emit;
    logic          rearm;

    assign out_can   = !r_ovalid || i_m_axis_tready;
    assign hdr_phase = r_hdr_cnt < 4'(szdd_pkg::HEADER_BYTES);
    assign hdr_last  = r_hdr_cnt == 4'(szdd_pkg::HEADER_BYTES - 1);
    assign size_new  = {r_in_byte, r_size[31:8]};

    always_comb begin
        priority if (r_hdr[31:0] == szdd_pkg::SIG_KWAJ) begin
            hdr_code = szdd_pkg::ST_KWAJ;
        end else if (r_hdr[31:0] != szdd_pkg::SIG_SZDD) begin
            hdr_code = szdd_pkg::ST_BAD_SIG;
        end else if (r_hdr[63:32] != szdd_pkg::MAGIC_CONST) begin
            hdr_code = szdd_pkg::ST_BAD_CONST;
        end else if (r_type != szdd_pkg::TYPE_A) begin
            hdr_code = szdd_pkg::ST_BAD_TYPE;
        end else if (size_new > r_max_len) begin
            hdr_code = szdd_pkg::ST_TOO_BIG;
        end else begin
            hdr_code = szdd_pkg::ST_DATA;
        end
    end

    assign hdr_err = hdr_last && (hdr_code != szdd_pkg::ST_DATA);
    assign dec_act = !hdr_phase && (r_prod < r_size);
    assign is_ctrl = r_fidx[3];
    assign is_lit  = dec_act && !is_ctrl && r_flag[r_fidx[2:0]];
    assign is_hold = dec_act && !is_ctrl && !r_flag[r_fidx[2:0]] && !r_pend[8];
    assign is_copy = dec_act && !is_ctrl && !r_flag[r_fidx[2:0]] && r_pend[8];

    assign copy_done = (r_left == 5'd1) || ((r_size - r_prod) == 32'd1);

    always_comb begin
        priority if (hdr_phase) begin
            end_code = szdd_pkg::ST_TOO_SMALL;
        end else if (r_prod >= r_size) begin
            end_code = szdd_pkg::ST_DONE;
        end else if (r_pend[8]) begin
            end_code = szdd_pkg::ST_TRUNC_REF;
        end else begin
            end_code = szdd_pkg::ST_TRUNC_OUT;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            szdd_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = szdd_pkg::S_DECODE;
                end
            end
            szdd_pkg::S_DECODE: begin
                priority if (r_err) begin
                    n_state = szdd_pkg::S_IDLE;
                end else if ((hdr_err || is_lit) && !out_can) begin
                    n_state = szdd_pkg::S_DECODE;
                end else if (hdr_err) begin
                    n_state = szdd_pkg::S_IDLE;
                end else if (is_copy) begin
                    n_state = szdd_pkg::S_COPY_RD;
                end else if (r_in_end) begin
                    n_state = szdd_pkg::S_END;
                end else begin
                    n_state = szdd_pkg::S_IDLE;
                end
            end
            szdd_pkg::S_COPY_RD: begin
                n_state = szdd_pkg::S_COPY_WR;
            end
            szdd_pkg::S_COPY_WR: begin
                if (out_can) begin
                    priority if (!copy_done) begin
                        n_state = szdd_pkg::S_COPY_RD;
                    end else if (r_in_end) begin
                        n_state = szdd_pkg::S_END;
                    end else begin
                        n_state = szdd_pkg::S_IDLE;
                    end
                end
            end
            szdd_pkg::S_END: begin
                if (out_can) begin
                    n_state = szdd_pkg::S_IDLE;
                end
            end
            default: n_state = szdd_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        out_load = 1'b0;
        out_byte = 8'h00;
        out_stat = szdd_pkg::ST_DATA;
        out_last = 1'b0;
        emit     = 1'b0;
        rearm    = 1'b0;
        unique case (r_state)
            szdd_pkg::S_DECODE: begin
                priority if (r_err) begin
                    rearm = r_in_end;
                end else if (hdr_err) begin
                    out_load = out_can;
                    out_stat = hdr_code;
                    out_last = 1'b1;
                    rearm    = out_can && r_in_end;
                end else if (is_lit) begin
                    out_load = out_can;
                    out_byte = r_in_byte;
                    out_last = !r_in_end;
                    emit     = out_can;
                end else begin
                    out_load = 1'b0;
                end
            end
            szdd_pkg::S_COPY_WR: begin
                out_load = out_can;
                out_byte = win_q;
                out_last = copy_done && !r_in_end;
                emit     = out_can;
            end
            szdd_pkg::S_END: begin
                out_load = out_can;
                out_stat = end_code;
                out_last = 1'b1;
                rearm    = out_can;
            end
            default: out_load = 1'b0;
        endcase
    end

    assign win_req.we    = emit;
    assign win_req.waddr = r_wpos;
    assign win_req.wdata = out_byte;
    assign win_req.re    = (r_state == szdd_pkg::S_COPY_RD);
    assign win_req.raddr = r_pos;

    szdd_win u_win (
        .i_clk   (i_clk),
        .i_req   (win_req),
        .i_start (r_wstart),
        .i_fill  (r_fill),
        .o_rdata (win_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= szdd_pkg::S_IDLE;
            r_max_len <= szdd_pkg::MAX_LEN_RESET;
            r_wstart  <= szdd_pkg::WSTART_RESET;
            r_wpos    <= szdd_pkg::WSTART_RESET;
            r_fill    <= '0;
            r_hdr_cnt <= '0;
            r_hdr     <= '0;
            r_type    <= '0;
            r_size    <= '0;
            r_prod    <= '0;
            r_flag    <= '0;
            r_fidx    <= 4'd8;
            r_pend    <= '0;
            r_err     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (out_load) begin
                r_ovalid <= 1'b1;
                r_obyte  <= out_byte;
                r_ostat  <= out_stat;
                r_olast  <= out_last;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            if (r_state == szdd_pkg::S_IDLE && i_s_axis_tvalid) begin
                r_in_byte <= i_s_axis_tdata;
                r_in_end  <= i_s_axis_tlast;
            end

            if (emit) begin
                r_wpos <= r_wpos + AW'(1);
                r_prod <= r_prod + 32'd1;
                if (r_fill != (AW + 1)'(szdd_pkg::WINDOW_SIZE)) begin
                    r_fill <= r_fill + (AW + 1)'(1);
                end
            end

            if (r_state == szdd_pkg::S_DECODE && !r_err) begin
                if (hdr_phase && (!hdr_err || out_can)) begin
                    r_hdr_cnt <= r_hdr_cnt + 4'd1;
                    if (!r_hdr_cnt[3]) begin
                        r_hdr <= {r_in_byte, r_hdr[63:8]};
                    end else if (r_hdr_cnt == 4'd8) begin
                        r_type <= r_in_byte;
                    end else if (r_hdr_cnt >= 4'd10) begin
                        r_size <= size_new;
                    end
                    if (hdr_err) begin
                        r_err <= 1'b1;
                    end
                end
                if (dec_act && is_ctrl) begin
                    r_flag <= r_in_byte;
                    r_fidx <= '0;
                end
                if (is_lit && out_can) begin
                    r_fidx <= r_fidx + 4'd1;
                end
                if (is_hold) begin
                    r_pend <= {1'b1, r_in_byte};
                end
                if (is_copy) begin
                    r_pos  <= {r_in_byte[7:4], r_pend[7:0]};
                    r_left <= 5'(r_in_byte[3:0]) + 5'(szdd_pkg::MIN_MATCH);
                end
            end

            if (r_state == szdd_pkg::S_COPY_WR && out_can) begin
                r_pos  <= r_pos + AW'(1);
                r_left <= r_left - 5'd1;
                if (copy_done) begin
                    r_pend <= '0;
                    r_fidx <= r_fidx + 4'd1;
                end
            end

            if (rearm) begin
                r_wpos    <= r_wstart;
                r_fill    <= '0;
                r_hdr_cnt <= '0;
                r_hdr     <= '0;
                r_type    <= '0;
                r_size    <= '0;
                r_prod    <= '0;
                r_flag    <= '0;
                r_fidx    <= 4'd8;
                r_pend    <= '0;
                r_err     <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    szdd_pkg::CFG_MAX_LEN: begin
                        r_max_len <= i_cfg_wdata;
                    end
                    szdd_pkg::CFG_WSTART: begin
                        r_wstart <= i_cfg_wdata[AW-1:0];
                        r_wpos   <= i_cfg_wdata[AW-1:0];
                        r_fill   <= '0;
                    end
                    default: r_max_len <= r_max_len;
                endcase
            end
        end
    end

    assign o_s_axis_tready = (r_state == szdd_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_obyte;
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tlast  = r_olast;

    // write pointer tracks the fill count until the window has wrapped
    a_wpos_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != (AW + 1)'(szdd_pkg::WINDOW_SIZE)) |-> (r_wpos == r_wstart + r_fill[AW-1:0]))
        else $error("write position out of step with fill count");

    a_copy_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == szdd_pkg::S_COPY_RD || r_state == szdd_pkg::S_COPY_WR)
        |-> (r_left != 5'd0 && r_pend[8] && r_prod < r_size))
        else $error("copy running without a live back-reference");

    a_err_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_hdr_cnt == 4'(szdd_pkg::HEADER_BYTES)))
        else $error("error latched before header complete");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostat != szdd_pkg::ST_DATA) |-> (r_olast && r_obyte == 8'h00))
        else $error("status word not final or carries data");

endmodule

// ----- dv/szdd_lzss_checker.sv -----
// szdd_lzss_checker: tracks input words and config writes of the SZDD LZSS decompressor,
// predicts every output word and compares it against the DUT output channel.
// Depends on szdd_pkg.
`timescale 1ns / 1ps

module szdd_lzss_checker
    import szdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [7:0]  i_in_tdata,    // [7:0] in_byte
    input  logic        i_in_tlast,
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [7:0]  i_out_tdata,   // [7:0] out_byte
    input  logic [3:0]  i_out_tuser,   // [3:0] status
    input  logic        i_out_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] status;
        logic       last;
    } t_out_word;

    logic [31:0]    max_len;
    logic [11:0]    win_start;
    logic [7:0]     win [WINDOW_SIZE];
    logic [11:0]    wr_pos;
    int             hdr_cnt;
    logic [63:0]    hdr_sig;
    logic [7:0]     hdr_type;
    logic [31:0]    orig_size;
    logic [31:0]    out_count;
    logic [7:0]     flags;
    int             flag_idx;
    logic [7:0]     ref_lo;
    logic           ref_held;
    logic           latched;
    t_out_word      expected_words[$];
    t_out_word      step_words[$];
    t_out_word      got_w;
    t_out_word      want_w;
    int             mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void refill_window();
        for (int i = 0; i < WINDOW_SIZE; i++)
            win[i] = (i < int'(win_start)) ? FILL_SPACE : FILL_ZERO;
        wr_pos = win_start;
    endfunction

    function automatic void restart_file();
        refill_window();
        hdr_cnt   = 0;
        hdr_sig   = '0;
        hdr_type  = '0;
        orig_size = '0;
        out_count = '0;
        flags     = '0;
        flag_idx  = 8;
        ref_lo    = '0;
        ref_held  = 1'b0;
        latched   = 1'b0;
    endfunction

    function automatic void push_word(logic [7:0] d, logic [3:0] st);
        t_out_word w;
        w.data   = d;
        w.status = st;
        w.last   = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void produce(logic [7:0] d);
        win[wr_pos] = d;
        wr_pos      = wr_pos + 12'd1;
        out_count   = out_count + 32'd1;
        push_word(d, ST_DATA);
    endfunction

    function automatic logic [3:0] header_status();
        if (hdr_sig[31:0] == SIG_KWAJ)     return ST_KWAJ;
        if (hdr_sig[31:0] != SIG_SZDD)     return ST_BAD_SIG;
        if (hdr_sig[63:32] != MAGIC_CONST) return ST_BAD_CONST;
        if (hdr_type != TYPE_A)            return ST_BAD_TYPE;
        if (orig_size > max_len)           return ST_TOO_BIG;
        return ST_DATA;
    endfunction

    function automatic void decode_body(logic [7:0] b);
        logic [11:0] pos;
        int          len;
        if (flag_idx >= 8) begin
            flags    = b;
            flag_idx = 0;
        end else if (flags[flag_idx]) begin
            produce(b);
            flag_idx++;
        end else if (!ref_held) begin
            ref_lo   = b;
            ref_held = 1'b1;
        end else begin
            pos = {b[7:4], ref_lo};
            len = int'(b[3:0]) + MIN_MATCH;
            for (int k = 0; k < len && out_count < orig_size; k++) begin
                produce(win[pos]);
                pos = pos + 12'd1;
            end
            ref_held = 1'b0;
            flag_idx++;
        end
    endfunction

    // expected words caused by one accepted input word
    function automatic void decode_file_byte(logic [7:0] b, logic fin);
        logic [3:0] st;
        logic       hdr_err;
        step_words.delete();
        hdr_err = 1'b0;
        if (latched) begin
            if (fin)
                restart_file();
        end else begin
            if (hdr_cnt < HEADER_BYTES) begin
                if (hdr_cnt < 8)
                    hdr_sig[8*hdr_cnt +: 8] = b;
                else if (hdr_cnt == 8)
                    hdr_type = b;
                else if (hdr_cnt >= 10)
                    orig_size[8*(hdr_cnt-10) +: 8] = b;
                hdr_cnt++;
                if (hdr_cnt == HEADER_BYTES) begin
                    st = header_status();
                    if (st != ST_DATA) begin
                        hdr_err = 1'b1;
                        push_word(8'h00, st);
                        if (fin)
                            restart_file();
                        else
                            latched = 1'b1;
                    end
                end
            end else if (out_count < orig_size) begin
                decode_body(b);
            end
            if (fin && !hdr_err) begin
                if (hdr_cnt < HEADER_BYTES)
                    st = ST_TOO_SMALL;
                else if (out_count >= orig_size)
                    st = ST_DONE;
                else if (ref_held)
                    st = ST_TRUNC_REF;
                else
                    st = ST_TRUNC_OUT;
                push_word(8'h00, st);
                restart_file();
            end
        end
        if (step_words.size() > 0)
            step_words[step_words.size()-1].last = 1'b1;
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_len   = MAX_LEN_RESET;
            win_start = WSTART_RESET;
            restart_file();
            expected_words.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                got_w.data   = i_out_tdata;
                got_w.status = i_out_tuser;
                got_w.last   = i_out_tlast;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word: data %02h status %0d last %0b",
                                 $time, got_w.data, got_w.status, got_w.last);
                end else begin
                    want_w = expected_words.pop_front();
                    if (want_w != got_w) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected data %02h status %0d last %0b,",
                                      " got data %02h status %0d last %0b"},
                                     $time, want_w.data, want_w.status, want_w.last,
                                     got_w.data, got_w.status, got_w.last);
                    end
                end
            end
            if (i_in_tvalid && i_in_tready)
                decode_file_byte(i_in_tdata, i_in_tlast);
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_MAX_LEN) begin
                    max_len = i_cfg_wdata;
                end else begin
                    win_start = i_cfg_wdata[11:0];
                    refill_window();
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_words.size();
    end

endmodule

// ----- dv/tb_szdd_lzss_decompressor.sv -----
// tb_szdd_lzss_decompressor: stimulus and verdict for the SZDD LZSS decompressor.
// Feeds directed and random SZDD files with random stalls; checking is done in
// szdd_lzss_checker. Depends on szdd_pkg, szdd_lzss_checker and the DUT.
`timescale 1ns / 1ps

module tb_szdd_lzss_decompressor;
    import szdd_pkg::*;

    localparam int NUM_PHASES  = 4;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYC  = 60;

    typedef enum int {
        FK_GOOD, FK_TRUNC_REF, FK_HUGE, FK_ZERO, FK_KWAJ, FK_BAD_SIG,
        FK_BAD_CONST, FK_BAD_TYPE, FK_TOO_BIG, FK_SHORT, FK_NOISE, FK_COUNT
    } t_file_kind;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = CFG_MAX_LEN;
    logic [31:0] cfg_wdata = 32'h0;

    int          fail_count;
    int          pending_words;
    logic        gaps_on   = 1'b0;
    logic        stalls_on = 1'b0;
    int          stall_left = 0;
    logic [31:0] max_len_now = MAX_LEN_RESET;
    logic [7:0]  file_bytes[$];
    int          file_body_len;

    always #10 clk = ~clk;

    szdd_lzss_decompressor uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    szdd_lzss_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_tvalid  (s_tvalid),
        .i_in_tready  (s_tready),
        .i_in_tdata   (s_tdata),
        .i_in_tlast   (s_tlast),
        .i_out_tvalid (m_tvalid),
        .i_out_tready (m_tready),
        .i_out_tdata  (m_tdata),
        .i_out_tuser  (m_tuser),
        .i_out_tlast  (m_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    // receiver stalls in bursts of random length while stalls are enabled
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic put_word(input logic [7:0] b, input logic l);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            put_word(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    task automatic write_reg(input logic addr, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (addr == CFG_MAX_LEN)
            max_len_now = val;
    endtask

    // wait until every expected word is out, then let the block go idle
    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        do begin
            @(posedge clk);
            guard++;
        end while (pending_words != 0 && guard < DRAIN_LIMIT);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic void add_header(logic [31:0] sig, logic [31:0] cst,
                                       logic [7:0] typ, logic [31:0] size);
        for (int i = 0; i < 4; i++) file_bytes.push_back(sig[8*i +: 8]);
        for (int i = 0; i < 4; i++) file_bytes.push_back(cst[8*i +: 8]);
        file_bytes.push_back(typ);
        file_bytes.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < 4; i++) file_bytes.push_back(size[8*i +: 8]);
    endfunction

    function automatic void add_ref();
        file_bytes.push_back(8'($urandom_range(0, 255)));
        file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_file(t_file_kind kind);
        logic [31:0] sig;
        logic [31:0] cst;
        logic [31:0] size;
        logic [7:0]  typ;
        logic [7:0]  flip;
        logic [7:0]  ctrl;
        int          idx;
        int          n;
        sig  = SIG_SZDD;
        cst  = MAGIC_CONST;
        typ  = TYPE_A;
        size = $urandom_range(1, 80);
        flip = 8'($urandom_range(1, 255));
        idx  = $urandom_range(0, 3);
        file_bytes.delete();
        case (kind)
            FK_KWAJ:      sig = SIG_KWAJ;
            FK_BAD_SIG:   sig[8*idx +: 8] = sig[8*idx +: 8] ^ flip;
            FK_BAD_CONST: cst[8*idx +: 8] = cst[8*idx +: 8] ^ flip;
            FK_BAD_TYPE:  typ = TYPE_A ^ flip;
            FK_TOO_BIG:   size = max_len_now + 32'd1;
            FK_ZERO:      size = 32'd0;
            FK_HUGE:      size = $urandom;
            FK_TRUNC_REF: size = 32'h0001_0000 | $urandom_range(0, 255);
            default: ;
        endcase
        add_header(sig, cst, typ, size);
        case (kind)
            FK_SHORT: begin
                n = $urandom_range(1, HEADER_BYTES - 1);
                while (file_bytes.size() > n) void'(file_bytes.pop_back());
            end
            FK_NOISE: begin
                file_bytes.delete();
                n = $urandom_range(1, 20);
                repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            FK_TRUNC_REF: begin
                file_bytes.push_back(8'h00);
                n = $urandom_range(0, 3);
                repeat (n) add_ref();
                file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            FK_GOOD, FK_HUGE, FK_ZERO, FK_TOO_BIG: begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    ctrl = 8'($urandom_range(0, 255));
                    file_bytes.push_back(ctrl);
                    for (int j = 0; j < 8; j++) begin
                        if (ctrl[j])
                            file_bytes.push_back(8'($urandom_range(0, 255)));
                        else
                            add_ref();
                    end
                end
            end
            default: ;
        endcase
        file_body_len = file_bytes.size();
        if (kind != FK_SHORT && kind != FK_NOISE && kind != FK_TRUNC_REF) begin
            n = $urandom_range(0, 3);
            repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic t_file_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return FK_GOOD;
        if (r < 63) return FK_TRUNC_REF;
        if (r < 68) return FK_HUGE;
        if (r < 71) return FK_ZERO;
        if (r < 74) return FK_KWAJ;
        if (r < 77) return FK_BAD_SIG;
        if (r < 80) return FK_BAD_CONST;
        if (r < 83) return FK_BAD_TYPE;
        if (r < 88) return FK_TOO_BIG;
        if (r < 93) return FK_SHORT;
        return FK_NOISE;
    endfunction

    initial begin
        int         file_no;
        int         sent;
        int         budget;
        logic       busy_phase;
        t_file_kind kind;

        file_no = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window start 4080: two literals, an overlapping 18-byte copy from the
        // first literal, a 3-byte copy from position 0, a literal, then a
        // trailing byte past the original size
        file_bytes = '{8'h53, 8'h5A, 8'h44, 8'h44, 8'h88, 8'hF0, 8'h27, 8'h33,
                       8'h41, 8'h00, 8'h18, 8'h00, 8'h00, 8'h00,
                       8'h13, 8'h00, 8'hFF, 8'hF0, 8'hFF, 8'h00, 8'h00, 8'h7E, 8'hAA};
        send_file();
        // header cut after one word
        file_bytes = '{8'hFF};
        send_file();
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_WSTART, 32'd0);
                    write_reg(CFG_MAX_LEN, MAX_LEN_RESET);
                    budget = 90;
                end
                1: begin
                    write_reg(CFG_WSTART, 32'd4095);
                    write_reg(CFG_MAX_LEN, 32'd0);
                    budget = 20;
                end
                2: begin
                    write_reg(CFG_WSTART, $urandom_range(0, 4095));
                    write_reg(CFG_MAX_LEN, $urandom_range(20, 60));
                    budget = 60;
                end
                default: begin
                    write_reg(CFG_WSTART, {20'h0, WSTART_RESET});
                    write_reg(CFG_MAX_LEN, MAX_LEN_RESET);
                    budget = 50;
                end
            endcase
            busy_phase = (ph != NUM_PHASES - 1);
            sent = 0;
            while (sent < budget) begin
                gaps_on    = busy_phase && $urandom_range(0, 2) != 0;
                stalls_on <= busy_phase && $urandom_range(0, 2) != 0;
                kind = (file_no < FK_COUNT) ? t_file_kind'(file_no) : pick_kind();
                file_no++;
                build_file(kind);
                send_file();
                sent += file_body_len;
            end
            drain();
        end

        if (fail_count == 0 && pending_words == 0) begin
            $display("szdd_lzss_decompressor regression: pass");
        end else begin
            $display("szdd_lzss_decompressor regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("szdd_lzss_decompressor regression: fail");
        $finish;
    end

endmodule
